// ----- rtl/gcs_pkg.sv -----
// ----------------------------------------------------------------------------
// gcs_pkg
// Shared types, op codes and calendar helpers for the Gregorian date stepper.
// ----------------------------------------------------------------------------
package gcs_pkg;

	localparam logic [1:0] OP_LOAD = 2'd0;
	localparam logic [1:0] OP_NEXT = 2'd1;
	localparam logic [1:0] OP_PREV = 2'd2;
	localparam logic [1:0] OP_NOP  = 2'd3;

	localparam logic [3:0] MONTH_JAN = 4'd1;
	localparam logic [3:0] MONTH_FEB = 4'd2;
	localparam logic [3:0] MONTH_DEC = 4'd12;
	localparam logic [4:0] DAY_FIRST = 5'd1;
	localparam logic [4:0] DAY_DEC31 = 5'd31;

	// Multiplicative inverse of 25 modulo 2**14 and the divisibility bound.
	localparam logic [13:0] INV25     = 14'd7209;
	localparam logic [13:0] DIV25_MAX = 14'd655;

	// Reciprocal of 7 for values below 512: x / 7 == (x * 293) >> 11.
	localparam logic [16:0] RECIP7 = 17'd293;

	typedef struct packed {
		logic [1:0]  op;
		logic [4:0]  load_day;
		logic [3:0]  load_month;
		logic [13:0] load_year;
	} gcs_in_t;

	typedef struct packed {
		logic [4:0]  out_day;
		logic [3:0]  out_month;
		logic [13:0] out_year;
		logic        valid_res;
		logic        leap;
		logic [8:0]  day_of_year;
		logic [5:0]  week_number;
	} gcs_out_t;

	typedef struct packed {
		logic [4:0]  day;
		logic [3:0]  month;
		logic [13:0] year;
		logic        leap;
	} gcs_date_t;

	// Divisible by 100 means divisible by 4 and 25; by 400 means by 16 and 25.
	function automatic logic is_leap(input logic [13:0] y);
		logic [13:0] prod;
		logic        div25;
		prod  = y * INV25;
		div25 = (prod <= DIV25_MAX);
		return (y[1:0] == 2'd0) && (!div25 || (y[3:0] == 4'd0));
	endfunction

	function automatic logic [4:0] month_len(input logic [3:0] m, input logic lp);
		logic [4:0] len;
		unique case (m)
			4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: len = 5'd31;
			4'd4, 4'd6, 4'd9, 4'd11:                   len = 5'd30;
			4'd2:                                      len = lp ? 5'd29 : 5'd28;
			default:                                   len = 5'd0;
		endcase
		return len;
	endfunction

	function automatic logic [8:0] days_before(input logic [3:0] m);
		logic [8:0] d;
		unique case (m)
			4'd1:    d = 9'd0;
			4'd2:    d = 9'd31;
			4'd3:    d = 9'd59;
			4'd4:    d = 9'd90;
			4'd5:    d = 9'd120;
			4'd6:    d = 9'd151;
			4'd7:    d = 9'd181;
			4'd8:    d = 9'd212;
			4'd9:    d = 9'd243;
			4'd10:   d = 9'd273;
			4'd11:   d = 9'd304;
			4'd12:   d = 9'd334;
			default: d = 9'd0;
		endcase
		return d;
	endfunction

endpackage

// ----- rtl/gcs_step.sv -----
// ----------------------------------------------------------------------------
// gcs_step
// Stored date registers and the load / next day / previous day update.
// ----------------------------------------------------------------------------
module gcs_step import gcs_pkg::*; #(
	parameter int LAST_YEAR = 9999
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      fire,
	input  gcs_in_t   cmd_s1,
	output gcs_date_t date_nxt
);

	logic [4:0]  day_q;
	logic [3:0]  month_q;
	logic [13:0] year_q;
	logic        leap_q;

	logic [4:0]  len_cur;
	logic [3:0]  month_prev;
	logic        cur_valid;
	logic [4:0]  day_n;
	logic [3:0]  month_n;
	logic [13:0] year_n;

	assign len_cur    = month_len(month_q, leap_q);
	assign month_prev = month_q - 4'd1;
	assign cur_valid  = (year_q >= 14'd1) && (year_q <= 14'(LAST_YEAR)) &&
		(month_q >= MONTH_JAN) && (month_q <= MONTH_DEC) &&
		(day_q >= DAY_FIRST) && (day_q <= len_cur);

	always_comb begin
		day_n   = day_q;
		month_n = month_q;
		year_n  = year_q;
		unique case (cmd_s1.op)
			OP_LOAD: begin
				day_n   = cmd_s1.load_day;
				month_n = cmd_s1.load_month;
				year_n  = cmd_s1.load_year;
			end
			OP_NEXT: begin
				if (cur_valid) begin
					if (day_q == len_cur) begin
						day_n = DAY_FIRST;
						if (month_q == MONTH_DEC) begin
							month_n = MONTH_JAN;
							year_n  = year_q + 14'd1;
						end else begin
							month_n = month_q + 4'd1;
						end
					end else begin
						day_n = day_q + 5'd1;
					end
				end
			end
			OP_PREV: begin
				if (cur_valid) begin
					if (day_q == DAY_FIRST) begin
						if (month_q == MONTH_JAN) begin
							month_n = MONTH_DEC;
							year_n  = year_q - 14'd1;
							day_n   = DAY_DEC31;
						end else begin
							month_n = month_prev;
							day_n   = month_len(month_prev, leap_q);
						end
					end else begin
						day_n = day_q - 5'd1;
					end
				end
			end
			default: begin
			end
		endcase
	end

	assign date_nxt.day   = day_n;
	assign date_nxt.month = month_n;
	assign date_nxt.year  = year_n;
	assign date_nxt.leap  = is_leap(year_n);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			day_q   <= DAY_FIRST;
			month_q <= MONTH_JAN;
			year_q  <= 14'd1;
			leap_q  <= 1'b0;
		end else if (fire) begin
			day_q   <= date_nxt.day;
			month_q <= date_nxt.month;
			year_q  <= date_nxt.year;
			leap_q  <= date_nxt.leap;
		end
	end

endmodule

// ----- rtl/gcs_report.sv -----
// ----------------------------------------------------------------------------
// gcs_report
// Validity, day of year and week number of a stored date.
// ----------------------------------------------------------------------------
module gcs_report import gcs_pkg::*; #(
	parameter int LAST_YEAR = 9999
) (
	input  gcs_date_t date,
	output gcs_out_t  res
);

	logic        valid;
	logic [8:0]  doy;
	logic [8:0]  doy_m1;
	logic [16:0] week_prod;
	logic [5:0]  week;

	assign valid = (date.year >= 14'd1) && (date.year <= 14'(LAST_YEAR)) &&
		(date.month >= MONTH_JAN) && (date.month <= MONTH_DEC) &&
		(date.day >= DAY_FIRST) && (date.day <= month_len(date.month, date.leap));

	assign doy = days_before(date.month) + 9'(date.day) +
		9'(date.leap && (date.month > MONTH_FEB));
	assign doy_m1    = doy - 9'd1;
	assign week_prod = 17'(doy_m1) * RECIP7;
	assign week      = week_prod[16:11] + 6'd1;

	assign res.out_day     = date.day;
	assign res.out_month   = date.month;
	assign res.out_year    = date.year;
	assign res.valid_res   = valid;
	assign res.leap        = date.leap;
	assign res.day_of_year = valid ? doy : 9'd0;
	assign res.week_number = valid ? week : 6'd0;

endmodule

// ----- rtl/gregorian_calendar_stepper_core.sv -----
// ----------------------------------------------------------------------------
// gregorian_calendar_stepper_core
// Gregorian date register with load, next day and previous day commands.
//
//   channel  direction  handshake              word
//   cmd      in         cmd_valid / cmd_ready  gcs_in_t
//   res      out        res_valid / res_ready  gcs_out_t
//
// One word per cycle is accepted while the result is not stalled. Its result
// passes through the input register, the date update and the result
// register before it is offered on the res channel.
// The stored date is updated as a word leaves the input register, so the
// next word in the input register already sees it, with no bubble.
// Reset sets the date to January 1 of year 1 and empties all stages.
// A stalled result holds its register; upstream stages fill and then stop.
// ----------------------------------------------------------------------------
module gregorian_calendar_stepper_core import gcs_pkg::*; #(
	parameter int LAST_YEAR = 9999
) (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     cmd_valid,
	output logic     cmd_ready,
	input  gcs_in_t  cmd,
	output logic     res_valid,
	input  logic     res_ready,
	output gcs_out_t res
);

	logic      v_s1, v_s2, v_s3;
	logic      rdy_s1, rdy_s2, rdy_s3;
	gcs_in_t   cmd_s1;
	gcs_date_t date_nxt;
	gcs_date_t date_s2;
	gcs_out_t  res_nxt;
	gcs_out_t  res_s3;

	assign rdy_s3    = !v_s3 || res_ready;
	assign rdy_s2    = !v_s2 || rdy_s3;
	assign rdy_s1    = !v_s1 || rdy_s2;
	assign cmd_ready = rdy_s1;

	gcs_step #(.LAST_YEAR(LAST_YEAR)) u_step (
		.clk      (clk),
		.arst_n   (arst_n),
		.fire     (v_s1 && rdy_s2),
		.cmd_s1   (cmd_s1),
		.date_nxt (date_nxt)
	);

	gcs_report #(.LAST_YEAR(LAST_YEAR)) u_report (
		.date (date_s2),
		.res  (res_nxt)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			if (rdy_s1) v_s1 <= cmd_valid;
			if (rdy_s2) v_s2 <= v_s1;
			if (rdy_s3) v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd_valid && rdy_s1) cmd_s1 <= cmd;
		if (v_s1 && rdy_s2) date_s2 <= date_nxt;
		if (v_s2 && rdy_s3) res_s3 <= res_nxt;
	end

	assign res_valid = v_s3;
	assign res       = res_s3;

endmodule

// ----- rtl/gcs_checker.sv -----
// ----------------------------------------------------------------------------
// gcs_checker
// Port-level checks for the date stepper, bound to the top level.
// ----------------------------------------------------------------------------
module gcs_checker import gcs_pkg::*; (
	input logic     clk,
	input logic     arst_n,
	input logic     res_valid,
	input logic     res_ready,
	input gcs_out_t res
);

	// A stalled result word must hold.
	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> res_valid && $stable(res))
		else $error("result word changed while stalled");

	a_invalid_zero: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res.valid_res |-> res.day_of_year == 9'd0 && res.week_number == 6'd0)
		else $error("invalid date reports nonzero ordinal");

	a_valid_range: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res.valid_res |-> res.out_month >= MONTH_JAN &&
			res.out_month <= MONTH_DEC && res.out_day >= DAY_FIRST &&
			res.day_of_year >= 9'd1 && res.day_of_year <= 9'd366 &&
			res.week_number >= 6'd1 && res.week_number <= 6'd53)
		else $error("valid date with out-of-range fields");

	// Every leap year is a multiple of four.
	a_leap_mod4: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res.leap |-> res.out_year[1:0] == 2'd0)
		else $error("leap flag on a year not divisible by four");

endmodule

bind gregorian_calendar_stepper_core gcs_checker u_gcs_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.res_valid (res_valid),
	.res_ready (res_ready),
	.res       (res)
);
